// File: rtl/core/sfe_pkg.sv
// Shared types and constants of the stereo feedback echo.
// Used by sfe_lane and stereo_feedback_echo; depends on nothing.
`default_nettype none

package sfe_pkg;

    localparam int SFE_LINE_DEPTH  = 131072;
    localparam int SFE_SAMPLE_BITS = 16;

    localparam int SFE_CFG_W  = 17;
    localparam int SFE_FB_W   = 16;
    localparam int SFE_GAIN_W = 17;
    localparam int SFE_FRAC   = 16;

    localparam logic [SFE_FB_W-1:0]   SFE_FB_MAX  = 16'd58982;
    localparam logic [SFE_GAIN_W-1:0] SFE_WET_MAX = 17'd65536;
    localparam int                    SFE_DELAY_RST = 24000;
    localparam int                    SFE_ROUND     = 32768;

    typedef enum logic [1:0] {
        CFG_DELAY = 2'd0,
        CFG_FB    = 2'd1,
        CFG_WET   = 2'd2,
        CFG_MODE  = 2'd3
    } sfe_cfg_idx_t;

    // Where the delayed sample of an item comes from.
    typedef struct packed {
        logic hit;
        logic fwd_prev;
        logic fwd_hold;
    } sfe_fwd_t;

endpackage

`default_nettype wire

// File: rtl/core/stereo_feedback_echo.sv
// Top level of the stereo feedback echo: configuration, write position,
// pipeline control and the two delay-line memories. Depends on sfe_pkg,
// sfe_ram and sfe_lane.
`default_nettype none

// Takes one stereo pair per cycle unless the output stalls and returns one
// result per pair; out_valid rises once the item has passed the input
// register, the line read register, the gain products and the result
// register. Throughput is set by the two simple dual-port line memories,
// each read once and written once per item; a result still in the
// pipeline is forwarded to a following item that reads the same entry, so a
// delay of one sample runs at full rate. No clearing pass follows reset: the
// write position and a wrap flag tell which entries hold data, and entries
// not yet written read as zero. In mono mode the right line is filled with
// zeros on the first pass only and left alone afterwards. The user must write
// configuration only while idle, unenforced; out-of-range values are clamped.
module stereo_feedback_echo
    import sfe_pkg::*;
#(
    parameter int LINE_DEPTH  = SFE_LINE_DEPTH,
    parameter int SAMPLE_BITS = SFE_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic        [1:0]             cfg_addr,
    input  wire logic        [SFE_CFG_W-1:0]   cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] left_in,
    input  wire logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [SAMPLE_BITS-1:0] left_out,
    output logic signed      [SAMPLE_BITS-1:0] right_out
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = ((AW > SFE_CFG_W) ? AW : SFE_CFG_W) + 1;
    localparam int DRST = (SFE_DELAY_RST > LINE_DEPTH - 1) ? LINE_DEPTH - 1
                                                          : SFE_DELAY_RST;
    localparam logic [CW-1:0] DMAX = CW'(LINE_DEPTH - 1);

    // configuration
    logic [AW-1:0]         delay_reg;
    logic [SFE_FB_W-1:0]   fb_reg;
    logic [SFE_GAIN_W-1:0] wet_reg;
    logic                  stereo_reg;
    logic [CW-1:0]         delay_ext;
    logic [AW-1:0]         delay_next;

    // write position
    logic [AW-1:0] wp_reg;
    logic          wrapped_reg;
    logic [AW-1:0] raddr_next;
    logic          hit_next;

    // pipeline
    logic adv;
    logic accept;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] s1_left_reg, s1_right_reg;
    logic [AW-1:0]                 s1_waddr_reg, s1_raddr_reg;
    logic                          s1_hit_reg, s1_wrap_reg;

    logic signed [SAMPLE_BITS-1:0] s2_left_reg, s2_right_reg;
    logic [AW-1:0]                 s2_waddr_reg;
    logic                          s2_wrap_reg;
    sfe_fwd_t                      s2_fwd_l_reg, s2_fwd_r_reg;
    logic signed [SAMPLE_BITS-1:0] s2_fdat_l_reg, s2_fdat_r_reg;

    logic [AW-1:0] s3_waddr_reg;
    logic          s3_wrap_reg;

    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    logic signed [SAMPLE_BITS-1:0] l_fb_sum, l_wet_sum, r_fb_sum, r_wet_sum;
    logic signed [SAMPLE_BITS-1:0] l_rdata, r_rdata;
    logic signed [SAMPLE_BITS-1:0] r_wdata;
    logic                          l_we, r_we;
    logic                          s2_rwe, s3_rwe;
    sfe_fwd_t                      fwd_l_next, fwd_r_next;

    // configuration write, clamped
    assign delay_ext = CW'(cfg_wdata);

    always_comb
    begin
        priority if (delay_ext == '0)
        begin
            delay_next = AW'(1);
        end
        else if (delay_ext > DMAX)
        begin
            delay_next = AW'(LINE_DEPTH - 1);
        end
        else
        begin
            delay_next = delay_ext[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= AW'(DRST);
            fb_reg     <= '0;
            wet_reg    <= '0;
            stereo_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (sfe_cfg_idx_t'(cfg_addr))
                CFG_DELAY: delay_reg <= delay_next;
                CFG_FB:    fb_reg <= (cfg_wdata[SFE_FB_W-1:0] > SFE_FB_MAX)
                                     ? SFE_FB_MAX : cfg_wdata[SFE_FB_W-1:0];
                CFG_WET:   wet_reg <= (cfg_wdata > SFE_WET_MAX)
                                      ? SFE_WET_MAX : cfg_wdata;
                CFG_MODE:  stereo_reg <= cfg_wdata[0];
            endcase
        end
    end

    // read address and fill test for the incoming item
    always_comb
    begin
        if (wp_reg >= delay_reg)
        begin
            raddr_next = wp_reg - delay_reg;
        end
        else
        begin
            raddr_next = AW'((AW+1)'(wp_reg) + (AW+1)'(LINE_DEPTH)
                             - (AW+1)'(delay_reg));
        end
    end

    assign hit_next = wrapped_reg || (wp_reg >= delay_reg);

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // line writes
    assign s2_rwe  = stereo_reg || !s2_wrap_reg;
    assign s3_rwe  = stereo_reg || !s3_wrap_reg;
    assign l_we    = adv && s3_valid_reg;
    assign r_we    = adv && s3_valid_reg && s3_rwe;
    assign r_wdata = stereo_reg ? r_fb_sum : '0;

    // forwarding from items still ahead in the pipeline
    assign fwd_l_next = '{
        hit:      s1_hit_reg,
        fwd_prev: s2_valid_reg && (s2_waddr_reg == s1_raddr_reg),
        fwd_hold: s3_valid_reg && (s3_waddr_reg == s1_raddr_reg)
    };
    assign fwd_r_next = '{
        hit:      s1_hit_reg,
        fwd_prev: s2_valid_reg && s2_rwe && (s2_waddr_reg == s1_raddr_reg),
        fwd_hold: s3_valid_reg && s3_rwe && (s3_waddr_reg == s1_raddr_reg)
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (wp_reg == AW'(LINE_DEPTH - 1))
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + AW'(1);
                end
            end
            if (adv)
            begin
                s1_valid_reg  <= in_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_left_reg  <= left_in;
            s1_right_reg <= right_in;
            s1_waddr_reg <= wp_reg;
            s1_raddr_reg <= raddr_next;
            s1_hit_reg   <= hit_next;
            s1_wrap_reg  <= wrapped_reg;
        end
        if (adv)
        begin
            s2_left_reg   <= s1_left_reg;
            s2_right_reg  <= s1_right_reg;
            s2_waddr_reg  <= s1_waddr_reg;
            s2_wrap_reg   <= s1_wrap_reg;
            s2_fwd_l_reg  <= fwd_l_next;
            s2_fwd_r_reg  <= fwd_r_next;
            s2_fdat_l_reg <= l_fb_sum;
            s2_fdat_r_reg <= r_wdata;
            s3_waddr_reg  <= s2_waddr_reg;
            s3_wrap_reg   <= s2_wrap_reg;
            left_out_reg  <= l_wet_sum;
            right_out_reg <= stereo_reg ? r_wet_sum : '0;
        end
    end

    sfe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_left_line (
        .clk   (clk),
        .we    (l_we),
        .waddr (s3_waddr_reg),
        .wdata (l_fb_sum),
        .re    (adv),
        .raddr (s1_raddr_reg),
        .rdata (l_rdata)
    );

    sfe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_right_line (
        .clk   (clk),
        .we    (r_we),
        .waddr (s3_waddr_reg),
        .wdata (r_wdata),
        .re    (adv),
        .raddr (s1_raddr_reg),
        .rdata (r_rdata)
    );

    sfe_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left_lane (
        .clk      (clk),
        .adv      (adv),
        .sample   (s2_left_reg),
        .fwd      (s2_fwd_l_reg),
        .fwd_data (s2_fdat_l_reg),
        .ram_data (l_rdata),
        .fb_gain  ({1'b0, fb_reg}),
        .wet_gain (wet_reg),
        .fb_sum   (l_fb_sum),
        .wet_sum  (l_wet_sum)
    );

    sfe_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right_lane (
        .clk      (clk),
        .adv      (adv),
        .sample   (s2_right_reg),
        .fwd      (s2_fwd_r_reg),
        .fwd_data (s2_fdat_r_reg),
        .ram_data (r_rdata),
        .fb_gain  ({1'b0, fb_reg}),
        .wet_gain (wet_reg),
        .fb_sum   (r_fb_sum),
        .wet_sum  (r_wet_sum)
    );

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

`ifndef SYNTHESIS
    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (wp_reg != AW'(LINE_DEPTH - 1)))
        |=> (wp_reg == $past(wp_reg) + AW'(1)))
        else $error("write position did not advance on an accepted item");

    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag cleared without reset");

    a_read_not_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit_reg) |-> (s1_raddr_reg != s1_waddr_reg))
        else $error("item reads the entry it is about to write");

    a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
        (r_we && !stereo_reg) |-> ((r_wdata == '0) && !s3_wrap_reg))
        else $error("right line written with data in mono mode");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sfe_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/sfe_lane.sv
// One channel of the echo datapath: delayed-sample select, gain products,
// rounding, sums and saturation. Depends on sfe_pkg.
`default_nettype none

module sfe_lane
    import sfe_pkg::*;
#(
    parameter int SAMPLE_BITS = SFE_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          adv,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire sfe_fwd_t                      fwd,
    input  wire logic signed [SAMPLE_BITS-1:0] fwd_data,
    input  wire logic signed [SAMPLE_BITS-1:0] ram_data,
    input  wire logic        [SFE_GAIN_W-1:0]  fb_gain,
    input  wire logic        [SFE_GAIN_W-1:0]  wet_gain,
    output logic signed      [SAMPLE_BITS-1:0] fb_sum,
    output logic signed      [SAMPLE_BITS-1:0] wet_sum
);

    localparam int PW = SAMPLE_BITS + SFE_GAIN_W + 1;
    localparam int SW = SAMPLE_BITS + 3;

    function automatic logic [SAMPLE_BITS-1:0] sat(input logic [SW-1:0] v);
        logic [SAMPLE_BITS-1:0] res;
        if (v[SW-1:SAMPLE_BITS-1] == {4{v[SW-1]}})
        begin
            res = v[SAMPLE_BITS-1:0];
        end
        else if (v[SW-1])
        begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [PW-1:0]          prod_fb_reg;
    logic signed [PW-1:0]          prod_wet_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic        [PW-1:0]          rnd_fb;
    logic        [PW-1:0]          rnd_wet;
    logic        [SW-1:0]          tot_fb;
    logic        [SW-1:0]          tot_wet;

    always_comb
    begin
        priority if (!fwd.hit)
        begin
            delayed = '0;
        end
        else if (fwd.fwd_prev)
        begin
            delayed = fb_sum;
        end
        else if (fwd.fwd_hold)
        begin
            delayed = fwd_data;
        end
        else
        begin
            delayed = ram_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_fb_reg  <= delayed * $signed({1'b0, fb_gain});
            prod_wet_reg <= delayed * $signed({1'b0, wet_gain});
            sample_reg   <= sample;
        end
    end

    // floor((p + 2^15) / 2^16), then add the dry sample
    assign rnd_fb  = prod_fb_reg + PW'(SFE_ROUND);
    assign rnd_wet = prod_wet_reg + PW'(SFE_ROUND);
    assign tot_fb  = {{3{sample_reg[SAMPLE_BITS-1]}}, sample_reg}
                   + {rnd_fb[PW-1], rnd_fb[PW-1:SFE_FRAC]};
    assign tot_wet = {{3{sample_reg[SAMPLE_BITS-1]}}, sample_reg}
                   + {rnd_wet[PW-1], rnd_wet[PW-1:SFE_FRAC]};

    assign fb_sum  = sat(tot_fb);
    assign wet_sum = sat(tot_wet);

endmodule

`default_nettype wire

// File: dv/tb_stereo_feedback_echo.sv
`timescale 1ns / 100ps
// Self-checking testbench for stereo_feedback_echo: a directed table and
// random phases over many register settings.
// Depends on sfe_pkg and the block's RTL; expected samples are computed here.
module tb_stereo_feedback_echo;
    import sfe_pkg::*;

    localparam int     DEPTH       = SFE_LINE_DEPTH;
    localparam int     RUN_LIMIT   = 1000000;
    localparam int     PHASES      = 10;
    localparam int     PHASE_LEN   = 53;
    localparam longint SMP_MAX     = (longint'(1) <<< (SFE_SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN     = -SMP_MAX - 1;

    typedef logic signed [SFE_SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t l;
        sample_t r;
    } echo_pair_t;

    typedef struct packed {
        logic                 is_cfg;
        sfe_cfg_idx_t         idx;
        logic [SFE_CFG_W-1:0] val;
        sample_t              l;
        sample_t              r;
        logic                 known;
        sample_t              xl;
        sample_t              xr;
    } plan_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_addr  = '0;
    logic [SFE_CFG_W-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    sample_t              left_in   = '0;
    sample_t              right_in  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    sample_t              left_out;
    sample_t              right_out;

    // predictor state
    sample_t               left_mem  [DEPTH];
    sample_t               right_mem [DEPTH];
    int                    wr_pos     = 0;
    int                    line_wraps = 0;
    logic [SFE_CFG_W-1:0]  cur_delay  = SFE_DELAY_RST;
    logic [SFE_FB_W-1:0]   cur_fb     = '0;
    logic [SFE_GAIN_W-1:0] cur_wet    = '0;
    logic                  cur_stereo = 1'b1;

    echo_pair_t echo_due [$];
    logic       no_idle     = 1'b0;
    int         n_pairs     = 0;
    int         n_checked   = 0;
    int         n_writes    = 0;
    int         n_bad       = 0;
    int         cycle_count = 0;

    stereo_feedback_echo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("FAIL stereo_feedback_echo");
            $finish;
        end
    end

    function automatic longint gain_round(sample_t s, logic [SFE_GAIN_W-1:0] g);
        longint p;
        p = longint'(s) * longint'(g) + longint'(SFE_ROUND);
        return p >>> SFE_FRAC;
    endfunction

    function automatic sample_t clip(longint v);
        if (v > SMP_MAX)
            return sample_t'(SMP_MAX);
        if (v < SMP_MIN)
            return sample_t'(SMP_MIN);
        return sample_t'(v);
    endfunction

    function automatic echo_pair_t echo_predict(sample_t l, sample_t r);
        int                    d;
        int                    rd;
        logic [SFE_FB_W-1:0]   fb;
        logic [SFE_GAIN_W-1:0] wet;
        sample_t               dl;
        sample_t               dr;
        echo_pair_t            res;
        d = int'(cur_delay);
        if (d < 1)
            d = 1;
        if (d > DEPTH - 1)
            d = DEPTH - 1;
        fb  = (cur_fb > SFE_FB_MAX) ? SFE_FB_MAX : cur_fb;
        wet = (cur_wet > SFE_WET_MAX) ? SFE_WET_MAX : cur_wet;
        rd  = (wr_pos + DEPTH - d) % DEPTH;
        dl  = left_mem[rd];
        left_mem[wr_pos] = clip(longint'(l) + gain_round(dl, {1'b0, fb}));
        res.l = clip(longint'(l) + gain_round(dl, wet));
        res.r = '0;
        if (cur_stereo)
        begin
            dr = right_mem[rd];
            right_mem[wr_pos] = clip(longint'(r) + gain_round(dr, {1'b0, fb}));
            res.r = clip(longint'(r) + gain_round(dr, wet));
        end
        wr_pos = wr_pos + 1;
        if (wr_pos == DEPTH)
        begin
            wr_pos = 0;
            line_wraps++;
        end
        return res;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic sample_t draw_sample();
        case ($urandom_range(0, 7))
            0:       return sample_t'(SMP_MAX);
            1:       return sample_t'(SMP_MIN);
            2:       return sample_t'(int'($urandom_range(0, 16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic plan_row_t row_cfg(sfe_cfg_idx_t idx, logic [SFE_CFG_W-1:0] val);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    function automatic plan_row_t row_pair(sample_t l, sample_t r);
        plan_row_t row;
        row   = '0;
        row.l = l;
        row.r = r;
        return row;
    endfunction

    function automatic plan_row_t row_known(sample_t l, sample_t r, sample_t xl, sample_t xr);
        plan_row_t row;
        row       = row_pair(l, r);
        row.known = 1'b1;
        row.xl    = xl;
        row.xr    = xr;
        return row;
    endfunction

    task automatic send_pair(sample_t l, sample_t r, logic known, sample_t xl, sample_t xr);
        int         gap;
        echo_pair_t got;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do @(posedge clk); while (!in_ready);
        got = echo_predict(l, r);
        if (known)
        begin
            got.l = xl;
            got.r = xr;
        end
        echo_due.push_back(got);
        n_pairs++;
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (echo_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(sfe_cfg_idx_t idx, logic [SFE_CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DELAY: cur_delay  = val;
            CFG_FB:    cur_fb     = val[SFE_FB_W-1:0];
            CFG_WET:   cur_wet    = val;
            CFG_MODE:  cur_stereo = val[0];
            default:   ;
        endcase
        n_writes++;
    endtask

    task automatic apply_settings(logic [SFE_CFG_W-1:0] dly, logic [SFE_FB_W-1:0] fb,
                                  logic [SFE_GAIN_W-1:0] wet, logic stereo);
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_FB, {1'b0, fb});
        write_reg(CFG_WET, wet);
        write_reg(CFG_MODE, {16'd0, stereo});
    endtask

    initial
    begin : result_side
        int         stall;
        echo_pair_t want;
        wait (rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (echo_due.size() == 0)
            begin
                n_bad++;
                $error("result with no item pending: left_out %0d right_out %0d",
                       left_out, right_out);
            end
            else
            begin
                want = echo_due.pop_front();
                n_checked++;
                if (left_out !== want.l)
                begin
                    n_bad++;
                    $error("left_out: expected %0d, got %0d", want.l, left_out);
                end
                if (right_out !== want.r)
                begin
                    n_bad++;
                    $error("right_out: expected %0d, got %0d", want.r, right_out);
                end
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t             plan [$];
        logic [SFE_CFG_W-1:0]  dly;
        logic [SFE_FB_W-1:0]   fb;
        logic [SFE_GAIN_W-1:0] wet;
        logic                  stereo;
        foreach (left_mem[i])
        begin
            left_mem[i]  = '0;
            right_mem[i] = '0;
        end
        plan = '{
            row_known(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000),
            row_known(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff),
            row_known('0, '0, '0, '0),
            row_known(-16'sd1, 16'sd1, -16'sd1, 16'sd1),
            row_known(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa),
            row_cfg(CFG_DELAY, 17'd0),
            row_cfg(CFG_FB, 17'd65535),
            row_cfg(CFG_WET, 17'd131071),
            row_pair(16'sh7fff, 16'sh8000),
            row_pair(16'sh7fff, 16'sh8000),
            row_pair('0, '0),
            row_pair('0, '0),
            row_cfg(CFG_FB, 17'd32768),
            row_cfg(CFG_WET, 17'd32768),
            row_pair(16'sd1, -16'sd1),
            row_pair(16'sd1, -16'sd1),
            row_pair(16'sd3, -16'sd3),
            row_pair('0, '0),
            row_pair('0, '0),
            row_cfg(CFG_MODE, 17'd0),
            row_pair(16'sd1000, 16'sd12345),
            row_pair(-16'sd1000, -16'sd1),
            row_cfg(CFG_MODE, 17'd1),
            row_cfg(CFG_DELAY, 17'(DEPTH - 1)),
            row_cfg(CFG_WET, 17'd65536),
            row_known(16'sd100, -16'sd100, 16'sd100, -16'sd100),
            row_known(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000),
            row_cfg(CFG_DELAY, 17'd2),
            row_cfg(CFG_FB, 17'd58982),
            row_pair(16'sh8000, 16'sh7fff),
            row_pair(16'sd12, -16'sd12),
            row_pair('0, '0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_pair(plan[i].l, plan[i].r, plan[i].known, plan[i].xl, plan[i].xr);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case ($urandom_range(0, 5))
                0:       dly = '0;
                1:       dly = 17'd1;
                2:       dly = 17'($urandom_range(2, 16));
                3:       dly = 17'($urandom_range(17, 600));
                4:       dly = 17'(DEPTH - 1);
                default: dly = 17'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       fb = '0;
                1:       fb = SFE_FB_MAX;
                2:       fb = 16'($urandom_range(SFE_FB_MAX + 1, 65535));
                default: fb = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       wet = '0;
                1:       wet = SFE_WET_MAX;
                2:       wet = 17'($urandom_range(SFE_WET_MAX + 1, 131071));
                default: wet = 17'($urandom);
            endcase
            stereo  = ($urandom_range(0, 3) != 0);
            no_idle = ($urandom_range(0, 3) == 0);
            apply_settings(dly, fb, wet, stereo);
            repeat (PHASE_LEN)
                send_pair(draw_sample(), draw_sample(), 1'b0, '0, '0);
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Ran %0d stereo pairs through %0d register writes; %0d results compared.",
                 n_pairs, n_writes, n_checked);
        $display("Delay lines wrapped %0d time(s); %0d mismatches seen.", line_wraps, n_bad);
        if (n_bad == 0)
            $display("PASS stereo_feedback_echo");
        else
            $display("FAIL stereo_feedback_echo");
        $finish;
    end

endmodule
